// ===== rtl/sis_pkg.sv =====
// ---------------------------------------------------------------------------
// sis_pkg: shared types and codes for the sorted interval set
// Entry layout in the range memory, command codes and status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  // one stored range, inclusive on both ends
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } entry_t;

  // command codes carried on in_tuser
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_CONTAINS = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // packed word widths on the stream ports
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

endpackage

`default_nettype wire

// ===== rtl/sorted_interval_set.sv =====
// ---------------------------------------------------------------------------
// sorted_interval_set: sorted table of disjoint signed ranges
// Add with merge and absorb, membership query, remove and read by index.
// ---------------------------------------------------------------------------
// The ranges live in one synchronous memory of MAX_RANGES entries, kept
// sorted and disjoint; every memory access is a registered read followed by
// an evaluate or write step. One command is handled at a time and the
// result word then sits in an output register. Add scans the entries up to
// the merge or insertion point, then an insertion shifts later entries down
// or a merge scans covered entries and compacts the tail; contains walks
// the entries below the queried value until an entry ends the walk; remove
// compacts the entries after the index; read fetches the one entry; an
// inverted range or bad index answers without a memory access. No clearing
// pass is needed after reset.
`default_nettype none

module sorted_interval_set
  import sis_pkg::*;
#(
  parameter int MAX_RANGES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // low_value [31:0], high_value [63:32], slot_index [68:64], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd [1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status [1:0], hit [2], entry_count [8:3], entry_low [40:9],
  // entry_high [72:41], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = (CW > 5) ? CW : 5;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD_RD = 4'd1;
  localparam logic [3:0] S_ADD_EV = 4'd2;
  localparam logic [3:0] S_ABS_RD = 4'd3;
  localparam logic [3:0] S_ABS_EV = 4'd4;
  localparam logic [3:0] S_CMP_RD = 4'd5;
  localparam logic [3:0] S_CMP_WR = 4'd6;
  localparam logic [3:0] S_SHF_RD = 4'd7;
  localparam logic [3:0] S_SHF_WR = 4'd8;
  localparam logic [3:0] S_QRY_RD = 4'd9;
  localparam logic [3:0] S_QRY_EV = 4'd10;
  localparam logic [3:0] S_GET_RD = 4'd11;
  localparam logic [3:0] S_GET_EV = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  // control registers
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] aux_r, aux_nxt;
  logic [CW-1:0] del_r, del_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic signed [31:0] lo_r, lo_nxt;
  logic signed [31:0] hi_r, hi_nxt;
  logic [4:0]         idx_r, idx_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic signed [31:0] res_lo_r, res_lo_nxt;
  logic signed [31:0] res_hi_r, res_hi_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // range memory
  entry_t        mem [MAX_RANGES];
  entry_t        mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic in_acc;
  logic full;
  logic out_free;
  logic idx_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign full       = (cnt_r == CW'(MAX_RANGES));
  assign out_free   = !out_valid_r || out_tready;
  assign idx_ok     = (IW'(in_tdata[68:64]) < IW'(cnt_r));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer and memory access control
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    aux_nxt        = aux_r;
    del_nxt        = del_r;
    out_valid_nxt  = out_valid_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_lo_nxt     = res_lo_r;
    res_hi_nxt     = res_hi_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(ptr_r);
    mem_wdata      = mem_rdata_r;
    mem_re         = 1'b0;
    mem_raddr      = AW'(ptr_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          lo_nxt         = in_tdata[31:0];
          hi_nxt         = in_tdata[63:32];
          idx_nxt        = in_tdata[68:64];
          res_status_nxt = ST_OK;
          res_hit_nxt    = 1'b0;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          ptr_nxt        = '0;
          del_nxt        = '0;
          unique case (in_tuser)
            CMD_ADD: begin
              if ($signed(in_tdata[31:0]) > $signed(in_tdata[63:32])) begin
                res_status_nxt = ST_BAD;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_ADD_RD;
              end
            end
            CMD_CONTAINS: begin
              state_nxt = S_QRY_RD;
            end
            CMD_REMOVE: begin
              if (idx_ok) begin
                ptr_nxt   = CW'(in_tdata[68:64]) + CW'(1);
                del_nxt   = CW'(1);
                state_nxt = S_CMP_RD;
              end else begin
                res_status_nxt = ST_BAD;
                state_nxt      = S_FIN;
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                state_nxt = S_GET_RD;
              end else begin
                res_status_nxt = ST_BAD;
                state_nxt      = S_FIN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // add: find the first entry that the new range touches or precedes
      S_ADD_RD: begin
        if (ptr_r < cnt_r) begin
          mem_re    = 1'b1;
          state_nxt = S_ADD_EV;
        end else if (full) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          aux_nxt   = cnt_r;
          state_nxt = S_SHF_RD;
        end
      end

      S_ADD_EV: begin
        if (lo_r < mem_rdata_r.lo) begin
          if (hi_r < mem_rdata_r.lo) begin
            // new range goes in front of this entry
            if (full) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              aux_nxt   = cnt_r;
              state_nxt = S_SHF_RD;
            end
          end else begin
            mem_we       = 1'b1;
            mem_wdata.lo = lo_r;
            if (hi_r > mem_rdata_r.hi) begin
              mem_wdata.hi = hi_r;
              ptr_nxt      = ptr_r + CW'(1);
              state_nxt    = S_ABS_RD;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end else if (lo_r <= mem_rdata_r.hi) begin
          if (hi_r > mem_rdata_r.hi) begin
            mem_we       = 1'b1;
            mem_wdata.hi = hi_r;
            ptr_nxt      = ptr_r + CW'(1);
            state_nxt    = S_ABS_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          ptr_nxt   = ptr_r + CW'(1);
          state_nxt = S_ADD_RD;
        end
      end

      // absorb: count covered entries after the widened one, trim a partial
      S_ABS_RD: begin
        if (ptr_r < cnt_r) begin
          mem_re    = 1'b1;
          state_nxt = S_ABS_EV;
        end else begin
          state_nxt = S_CMP_RD;
        end
      end

      S_ABS_EV: begin
        if (mem_rdata_r.lo > hi_r) begin
          state_nxt = S_CMP_RD;
        end else if (mem_rdata_r.hi <= hi_r) begin
          del_nxt   = del_r + CW'(1);
          ptr_nxt   = ptr_r + CW'(1);
          state_nxt = S_ABS_RD;
        end else begin
          mem_we       = 1'b1;
          mem_wdata.lo = hi_r + 32'sd1;
          state_nxt    = S_CMP_RD;
        end
      end

      // compaction: move the tail up over the deleted entries
      S_CMP_RD: begin
        if (del_r == '0) begin
          state_nxt = S_FIN;
        end else if (ptr_r < cnt_r) begin
          mem_re    = 1'b1;
          state_nxt = S_CMP_WR;
        end else begin
          cnt_nxt   = cnt_r - del_r;
          state_nxt = S_FIN;
        end
      end

      S_CMP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_r - del_r);
        ptr_nxt   = ptr_r + CW'(1);
        state_nxt = S_CMP_RD;
      end

      // insertion: shift entries down from the end, then write the new one
      S_SHF_RD: begin
        if (aux_r > ptr_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(aux_r - CW'(1));
          state_nxt = S_SHF_WR;
        end else begin
          mem_we       = 1'b1;
          mem_wdata.lo = lo_r;
          mem_wdata.hi = hi_r;
          cnt_nxt      = cnt_r + CW'(1);
          state_nxt    = S_FIN;
        end
      end

      S_SHF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(aux_r);
        aux_nxt   = aux_r - CW'(1);
        state_nxt = S_SHF_RD;
      end

      // contains: walk entries until one reaches the value
      S_QRY_RD: begin
        if (ptr_r < cnt_r) begin
          mem_re    = 1'b1;
          state_nxt = S_QRY_EV;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_QRY_EV: begin
        if (lo_r < mem_rdata_r.lo) begin
          state_nxt = S_FIN;
        end else if (lo_r <= mem_rdata_r.hi) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          ptr_nxt   = ptr_r + CW'(1);
          state_nxt = S_QRY_RD;
        end
      end

      // read by index
      S_GET_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_r);
        state_nxt = S_GET_EV;
      end

      S_GET_EV: begin
        res_lo_nxt = mem_rdata_r.lo;
        res_hi_nxt = mem_rdata_r.hi;
        state_nxt  = S_FIN;
      end

      // hand the result word to the output register
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, res_hi_r, res_lo_r, 6'(cnt_r), res_hit_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      aux_r       <= '0;
      del_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      aux_r       <= aux_nxt;
      del_r       <= del_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_lo_r     <= res_lo_nxt;
    res_hi_r     <= res_hi_nxt;
    out_data_r   <= out_data_nxt;
  end

  // range memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // entry count stays within the table
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RANGES))
    else $error("entry count above table size");

  // compaction never removes more entries than are stored
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP_RD || state_r == S_CMP_WR) |-> (del_r <= cnt_r))
    else $error("compaction distance exceeds entry count");

  // count only changes at the end of an insertion or a compaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      ($past(state_r) == S_SHF_RD || $past(state_r) == S_CMP_RD || !$past(rst_n)))
    else $error("entry count changed outside insert or compaction");

  // an accepted command always starts work
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted command did not leave idle");

  // memory is never read and written at the same entry in one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one entry");

endmodule

`default_nettype wire
